FILE: rtl/sid_pkg.sv
// Shared types for the signed integer divider.
// No dependencies; used by sid_cell and signed_integer_divider.
`default_nettype none

package sid_pkg;

    // Per-cycle control broadcast along the cell row.
    typedef struct packed {
        logic load;   // take fresh operand magnitudes
        logic step;   // one shift-and-subtract iteration
    } t_cell_ctl;

endpackage

`default_nettype wire

FILE: rtl/sid_cell.sv
// One bit slice of the restoring divider: remainder, dividend/quotient and divisor bits.
// Depends on sid_pkg (t_cell_ctl).
`default_nettype none

module sid_cell (
    input  wire                 i_clk,
    input  wire sid_pkg::t_cell_ctl i_ctl,
    input  wire                 i_num_load,  // dividend magnitude bit at load
    input  wire                 i_den_load,  // divisor magnitude bit at load
    input  wire                 i_rem_lo,    // shifted-in remainder bit from lower cell
    input  wire                 i_quo_lo,    // shifted-in dividend/quotient bit from lower cell
    input  wire                 i_borrow,    // trial subtract borrow from lower cell
    input  wire                 i_ge,        // trial subtract succeeded across the row
    output logic                o_rem,
    output logic                o_quo,
    output logic                o_borrow
);

    logic r_rem;
    logic r_quo;
    logic r_den;
    logic n_rem;
    logic n_quo;
    logic n_den;
    logic w_diff;

    // full subtractor on the shifted remainder bit
    assign w_diff   = i_rem_lo ^ r_den ^ i_borrow;
    assign o_borrow = (~i_rem_lo & r_den) | (~(i_rem_lo ^ r_den) & i_borrow);

    always_comb begin
        n_rem = r_rem;
        n_quo = r_quo;
        n_den = r_den;
        if (i_ctl.load) begin
            n_rem = 1'b0;
            n_quo = i_num_load;
            n_den = i_den_load;
        end else if (i_ctl.step) begin
            n_rem = i_ge ? w_diff : i_rem_lo;
            n_quo = i_quo_lo;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_den <= n_den;
    end

    assign o_rem = r_rem;
    assign o_quo = r_quo;

endmodule

`default_nettype wire

FILE: rtl/signed_integer_divider.sv
// Signed integer divider, quotient truncated toward zero, saturating special cases.
// Depends on sid_pkg and sid_cell (one cell per data bit).
//
// Usage:
//   Input channel: i_in_valid / o_in_stall carry one word of dividend and
//   divisor. Output channel: o_out_valid / i_out_stall carry the quotient and
//   the divide-by-zero and overflow flags. A word moves on a rising edge with
//   valid high and stall low.
//   One word is in flight at a time. After the input word is taken the cell
//   row runs DATA_WIDTH shift-and-subtract steps (one quotient bit per cycle,
//   set by the borrow ripple across the row), then the fix-up state applies the
//   sign and the saturating cases and registers the result word. A new word is
//   taken only after the result word has been taken.
//   o_in_stall is high from acceptance until the result word is taken.
//   While i_out_stall is high the result is held unchanged in its register.
//   Reset (i_rst_n low, synchronous) drops o_out_valid and returns to idle;
//   the cell row holds payload only and needs no reset.
`default_nettype none

module signed_integer_divider #(
    parameter int DATA_WIDTH = 32
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_in_valid,
    output logic                         o_in_stall,
    input  wire signed [DATA_WIDTH-1:0]  i_dividend,
    input  wire signed [DATA_WIDTH-1:0]  i_divisor,
    output logic                         o_out_valid,
    input  wire                          i_out_stall,
    output logic signed [DATA_WIDTH-1:0] o_quotient,
    output logic                         o_divide_by_zero,
    output logic                         o_overflowed
);

    localparam int CW = $clog2(DATA_WIDTH);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_FIX  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    localparam logic [DATA_WIDTH-1:0] SIGN_VAL = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam logic [DATA_WIDTH-1:0] MAX_POS  = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [CW-1:0]         LAST_CNT = CW'(DATA_WIDTH - 1);

    logic [1:0]            r_state, n_state;
    logic [CW-1:0]         r_count, n_count;
    logic                  r_neg_a, n_neg_a;
    logic                  r_neg_q, n_neg_q;
    logic                  r_dbz, n_dbz;
    logic                  r_ovf, n_ovf;
    logic                  r_out_valid, n_out_valid;
    logic [DATA_WIDTH-1:0] r_quotient, n_quotient;

    logic                  w_accept;
    logic                  w_neg_a, w_neg_b;
    logic [DATA_WIDTH-1:0] w_mag_a, w_mag_b;
    logic [DATA_WIDTH-1:0] w_rem, w_quo;
    logic [DATA_WIDTH:0]   w_borrow;
    logic                  w_ge;
    sid_pkg::t_cell_ctl    w_ctl;

    assign w_accept = i_in_valid && !o_in_stall;
    assign w_neg_a  = i_dividend[DATA_WIDTH-1];
    assign w_neg_b  = i_divisor[DATA_WIDTH-1];
    // magnitudes kept unsigned so the most negative value is representable
    assign w_mag_a  = w_neg_a ? (~i_dividend + 1'b1) : i_dividend;
    assign w_mag_b  = w_neg_b ? (~i_divisor + 1'b1) : i_divisor;

    assign w_ctl.load = w_accept;
    assign w_ctl.step = (r_state == S_RUN);

    // trial subtract succeeds when no borrow leaves the top cell
    assign w_borrow[0] = 1'b0;
    assign w_ge        = ~w_borrow[DATA_WIDTH];

    // cell row: remainder shifts up, dividend bits leave the top of the
    // quotient chain into cell 0's remainder, quotient bits enter at cell 0
    for (genvar g = 0; g < DATA_WIDTH; g++) begin : g_cell
        sid_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (w_ctl),
            .i_num_load (w_mag_a[g]),
            .i_den_load (w_mag_b[g]),
            .i_rem_lo   ((g == 0) ? w_quo[DATA_WIDTH-1] : w_rem[(g == 0) ? 0 : g-1]),
            .i_quo_lo   ((g == 0) ? w_ge : w_quo[(g == 0) ? 0 : g-1]),
            .i_borrow   (w_borrow[g]),
            .i_ge       (w_ge),
            .o_rem      (w_rem[g]),
            .o_quo      (w_quo[g]),
            .o_borrow   (w_borrow[g+1])
        );
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_neg_a     = r_neg_a;
        n_neg_q     = r_neg_q;
        n_dbz       = r_dbz;
        n_ovf       = r_ovf;
        n_out_valid = r_out_valid;
        n_quotient  = r_quotient;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_RUN;
                    n_count = LAST_CNT;
                    n_neg_a = w_neg_a;
                    n_neg_q = w_neg_a ^ w_neg_b;
                    n_dbz   = (i_divisor == '0);
                    n_ovf   = (i_dividend == SIGN_VAL) && (i_divisor == '1);
                end
            end
            S_RUN: begin
                n_count = r_count - 1'b1;
                if (r_count == '0) begin
                    n_state = S_FIX;
                end
            end
            S_FIX: begin
                // sign fix-up and saturating cases
                if (r_dbz) begin
                    n_quotient = r_neg_a ? SIGN_VAL : MAX_POS;
                end else if (r_ovf) begin
                    n_quotient = MAX_POS;
                end else begin
                    n_quotient = r_neg_q ? (~w_quo + 1'b1) : w_quo;
                end
                n_out_valid = 1'b1;
                n_state     = S_DONE;
            end
            S_DONE: begin
                if (!i_out_stall) begin
                    n_out_valid = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_neg_a    <= n_neg_a;
        r_neg_q    <= n_neg_q;
        r_dbz      <= n_dbz;
        r_ovf      <= n_ovf;
        r_quotient <= n_quotient;
    end

    assign o_in_stall       = (r_state != S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_quotient       = r_quotient;
    assign o_divide_by_zero = r_dbz;
    assign o_overflowed     = r_ovf;

    // result word is only presented in the hand-over state
    a_valid_in_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_state == S_DONE))
        else $error("result valid outside hand-over state");

    // the two special cases exclude each other
    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_dbz && r_ovf))
        else $error("divide-by-zero and overflow both set");

    // an accepted word starts a full-length iteration run
    a_start_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_RUN) && (r_count == LAST_CNT))
        else $error("iteration run not started after accept");

    // last iteration leads straight to the fix-up cycle
    a_run_to_fix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) && (r_count == '0) |=> (r_state == S_FIX))
        else $error("fix-up cycle missed after last iteration");

endmodule

`default_nettype wire

FILE: bench/quotient_checker.sv
`timescale 1ns / 100ps
// Watches both channels of the signed integer divider, works out each quotient
// word from the operands itself and compares it with what the divider returns.
// Stand-alone; instantiated by tb beside the divider.

module quotient_checker #(
    parameter int DW = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  logic [DW-1:0]        i_dividend,
    input  logic [DW-1:0]        i_divisor,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  logic [DW-1:0]        i_quotient,
    input  logic                 i_divide_by_zero,
    input  logic                 i_overflowed,
    output int                   o_mismatches,
    output int                   o_words_in_flight
);

    localparam logic [DW-1:0] MOST_NEG = {1'b1, {(DW-1){1'b0}}};
    localparam logic [DW-1:0] MOST_POS = ~MOST_NEG;

    typedef struct packed {
        logic [DW-1:0] quotient;
        logic          divide_by_zero;
        logic          overflowed;
    } t_quotient_word;

    t_quotient_word expected_quotients[$];

    initial begin
        o_mismatches      = 0;
        o_words_in_flight = 0;
    end

    // Truncating signed division: restoring shift-and-subtract on magnitudes.
    function automatic t_quotient_word predict_quotient(input logic [DW-1:0] num,
                                                        input logic [DW-1:0] den);
        logic [DW-1:0]  mag_num;
        logic [DW-1:0]  mag_den;
        logic [DW-1:0]  mag_quo;
        logic [DW:0]    rem;
        logic           neg_num;
        logic           neg_den;
        int             bit_idx;
        t_quotient_word res;
        neg_num = num[DW-1];
        neg_den = den[DW-1];
        res     = '0;
        if (den == '0) begin
            res.divide_by_zero = 1'b1;
            res.quotient       = neg_num ? MOST_NEG : MOST_POS;
        end else if (num == MOST_NEG && den == '1) begin
            res.overflowed = 1'b1;
            res.quotient   = MOST_POS;
        end else begin
            mag_num = neg_num ? -num : num;
            mag_den = neg_den ? -den : den;
            rem     = '0;
            mag_quo = '0;
            for (bit_idx = DW - 1; bit_idx >= 0; bit_idx--) begin
                rem = {rem[DW-1:0], mag_num[bit_idx]};
                if (rem >= {1'b0, mag_den}) begin
                    rem              = rem - {1'b0, mag_den};
                    mag_quo[bit_idx] = 1'b1;
                end
            end
            res.quotient = (neg_num != neg_den) ? -mag_quo : mag_quo;
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_quotient_word want;
        t_quotient_word got;
        int             popped;
        int             pushed;
        int             bad;
        popped = 0;
        pushed = 0;
        bad    = 0;
        if (i_rst_n) begin
            // result side first: a result on the same edge as an operand word
            // always belongs to an earlier word
            if (i_out_valid && !i_out_stall) begin
                got = '{i_quotient, i_divide_by_zero, i_overflowed};
                if (expected_quotients.size() == 0) begin
                    bad = 1;
                    if (o_mismatches < 10)
                        $display("%0t: unexpected result word q=%0d dbz=%b ovf=%b",
                                 $realtime, $signed(got.quotient), got.divide_by_zero,
                                 got.overflowed);
                end else begin
                    want   = expected_quotients.pop_front();
                    popped = 1;
                    if (got.quotient !== want.quotient
                            || got.divide_by_zero !== want.divide_by_zero
                            || got.overflowed !== want.overflowed) begin
                        bad = 1;
                        if (o_mismatches < 10)
                            $display("%0t: exp q=%0d dbz=%b ovf=%b, got q=%0d dbz=%b ovf=%b",
                                     $realtime, $signed(want.quotient), want.divide_by_zero,
                                     want.overflowed, $signed(got.quotient),
                                     got.divide_by_zero, got.overflowed);
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                expected_quotients.push_back(predict_quotient(i_dividend, i_divisor));
                pushed = 1;
            end
        end
        o_mismatches      <= o_mismatches + bad;
        o_words_in_flight <= o_words_in_flight + pushed - popped;
    end

endmodule

FILE: bench/tb.sv
`timescale 1ns / 100ps
// Top of the signed integer divider bench: clock, reset, operand words and
// output stalls, plus the final verdict. Needs signed_integer_divider and quotient_checker.

module tb;

    localparam int DW           = 32;
    localparam int RANDOM_WORDS = 830;
    localparam logic [DW-1:0] MOST_NEG = {1'b1, {(DW-1){1'b0}}};
    localparam logic [DW-1:0] MOST_POS = ~MOST_NEG;
    localparam logic [DW-1:0] MINUS_ONE = '1;

    // output stall patterns, each held for a random stretch
    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_COIN,
        STALL_HEAVY,
        STALL_PULSE
    } t_stall_pattern;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  i_out_stall = 1'b0;
    logic signed [DW-1:0]  i_dividend;
    logic signed [DW-1:0]  i_divisor;
    logic                  o_in_stall;
    logic                  o_out_valid;
    logic signed [DW-1:0]  o_quotient;
    logic                  o_divide_by_zero;
    logic                  o_overflowed;

    int                    mismatches;
    int                    words_in_flight;

    t_stall_pattern        stall_mode = STALL_NONE;
    int                    stall_left = 0;

    signed_integer_divider #(
        .DATA_WIDTH (DW)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_dividend       (i_dividend),
        .i_divisor        (i_divisor),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_quotient       (o_quotient),
        .o_divide_by_zero (o_divide_by_zero),
        .o_overflowed     (o_overflowed)
    );

    quotient_checker #(
        .DW (DW)
    ) checker_i (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .i_in_stall        (o_in_stall),
        .i_dividend        (i_dividend),
        .i_divisor         (i_divisor),
        .i_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .i_quotient        (o_quotient),
        .i_divide_by_zero  (o_divide_by_zero),
        .i_overflowed      (o_overflowed),
        .o_mismatches      (mismatches),
        .o_words_in_flight (words_in_flight)
    );

    // 4 ns period
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Receiver side: stall pattern of its own, switched after a random stretch.
    // Includes a no-stall pattern so there are stretches at full rate.
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode <= t_stall_pattern'($urandom_range(0, 3));
            stall_left <= $urandom_range(20, 200);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            STALL_NONE:  i_out_stall <= 1'b0;
            STALL_COIN:  i_out_stall <= ($urandom_range(0, 1) == 1);
            STALL_HEAVY: i_out_stall <= ($urandom_range(0, 7) != 0);
            default:     i_out_stall <= stall_left[3];
        endcase
    end

    // Hold an operand word on the channel until it is taken. Called just after
    // a rising edge; valid stays high between back-to-back words.
    task automatic send_word(input logic [DW-1:0] num, input logic [DW-1:0] den);
        i_in_valid <= 1'b1;
        i_dividend <= num;
        i_divisor  <= den;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
    endtask

    // Drop valid and wait for every outstanding result word. The extra edge
    // lets the checker's in-flight count catch up with the last accepted word.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (words_in_flight != 0)
            @(posedge i_clk);
    endtask

    // Small signed value in -limit..limit, zero included
    function automatic logic [DW-1:0] small_signed(input int unsigned limit);
        logic [DW-1:0] mag;
        mag = DW'($urandom_range(0, limit));
        return ($urandom_range(0, 1) == 1) ? -mag : mag;
    endfunction

    // Picks from the corner values of the operand range
    function automatic logic [DW-1:0] corner_value();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return DW'(1);
            2:       return MINUS_ONE;
            3:       return MOST_NEG;
            4:       return MOST_POS;
            5:       return MOST_NEG + DW'(1);
            6:       return DW'(2);
            default: return -DW'(2);
        endcase
    endfunction

    initial begin
        logic [DW-1:0] num;
        logic [DW-1:0] den;
        int            sent;
        int            burst_len;
        int            gap;
        int            pick;

        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_dividend <= '0;
        i_divisor  <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // --- directed words, back to back ---
        // zero divisor: non-negative dividend saturates high, negative low
        send_word('0, '0);
        send_word(DW'(5), '0);
        send_word(MOST_POS, '0);
        send_word(MINUS_ONE, '0);
        send_word(MOST_NEG, '0);
        // the one overflow case, and its near neighbours
        send_word(MOST_NEG, MINUS_ONE);
        send_word(MOST_NEG, DW'(1));
        send_word(MOST_NEG + DW'(1), MINUS_ONE);
        send_word(MOST_POS, MINUS_ONE);
        send_word(MOST_POS, DW'(1));
        send_word(MOST_NEG, MOST_NEG);
        send_word(MOST_POS, MOST_NEG);
        send_word(MOST_NEG, MOST_POS);
        send_word(MOST_POS, MOST_POS);
        // truncation toward zero in all four sign combinations
        send_word(DW'(7), DW'(2));
        send_word(-DW'(7), DW'(2));
        send_word(DW'(7), -DW'(2));
        send_word(-DW'(7), -DW'(2));
        // divisor larger in magnitude than dividend gives zero; then -1 / -1 and MOST_NEG / 2
        send_word(DW'(3), -DW'(4));
        send_word('0, MOST_NEG);
        send_word(MINUS_ONE, MINUS_ONE);
        send_word(MOST_NEG, DW'(2));

        // pause until the directed results are all back
        drain_results();

        // --- random words in bursts with random gaps ---
        sent = 0;
        while (sent < RANDOM_WORDS) begin
            burst_len = $urandom_range(1, 8);
            for (int k = 0; k < burst_len && sent < RANDOM_WORDS; k++) begin
                pick = $urandom_range(0, 99);
                if (pick < 35) begin
                    num = DW'({$urandom, $urandom});
                    den = DW'({$urandom, $urandom});
                end else if (pick < 60) begin
                    // wide dividend over short divisor: long quotients
                    num = DW'({$urandom, $urandom});
                    den = small_signed(255);
                end else if (pick < 75) begin
                    num = small_signed(1000);
                    den = small_signed(40);
                end else if (pick < 85) begin
                    num = small_signed(1000);
                    den = DW'({$urandom, $urandom});
                end else if (pick < 92) begin
                    num = corner_value();
                    den = corner_value();
                end else if (pick < 96) begin
                    num = DW'({$urandom, $urandom});
                    den = '0;
                end else begin
                    num = MOST_NEG;
                    den = ($urandom_range(0, 1) == 1) ? MINUS_ONE : small_signed(3);
                end
                send_word(num, den);
                sent++;
            end
            if (sent == RANDOM_WORDS / 2 || (sent > RANDOM_WORDS / 2
                    && sent - burst_len < RANDOM_WORDS / 2)) begin
                // mid-run pause with the pipe fully emptied
                drain_results();
            end else if ($urandom_range(0, 3) != 0) begin
                // gap long enough to land on any phase of a divide
                gap = $urandom_range(1, 45);
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end

        drain_results();
        // room for any stray result word after the last one expected
        repeat (80) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #4000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
